// ===== sv/dbchs_pkg.sv =====
package dbchs_pkg;

  // block configuration
  localparam int NUM_DEVICES       = 10;
  localparam int DEVICES_PER_DRIVE = 5;
  localparam int BLOCK_BYTES       = 1024;
  localparam int SECTORS_PER_TRACK = 17;

  // fixed geometry
  localparam int SECTOR_BYTES  = 512;
  localparam int SECTOR_SHIFT  = $clog2(SECTOR_BYTES);
  localparam int BLOCK_SHIFT   = $clog2(BLOCK_BYTES);
  localparam int BLOCK_SECTORS = BLOCK_BYTES / SECTOR_BYTES;
  localparam int DEV_IDX_W     = $clog2(NUM_DEVICES);
  localparam int BLK_SECTOR_W  = 32 - SECTOR_SHIFT;

  // divider sizing: absolute sector is one bit wider than a table entry
  localparam int SECTOR_W    = 33;
  localparam int DIV_W       = 6;
  localparam int RADIX_BITS  = 8;
  localparam int DIV_CYCLES  = (SECTOR_W + RADIX_BITS - 1) / RADIX_BITS;
  localparam int DIVIDEND_W  = DIV_CYCLES * RADIX_BITS;
  localparam int STEP_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // command opcodes
  localparam logic [7:0] OP_READ  = 8'h08;
  localparam logic [7:0] OP_WRITE = 8'h0a;

  // command byte positions
  localparam logic [2:0] BYTE_OPCODE   = 3'd0;
  localparam logic [2:0] BYTE_HEAD     = 3'd1;
  localparam logic [2:0] BYTE_SECTOR   = 3'd2;
  localparam logic [2:0] BYTE_CYLINDER = 3'd3;
  localparam logic [2:0] BYTE_BLOCKS   = 3'd4;
  localparam logic [2:0] BYTE_CONTROL  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_HEADS_FIRST    = 2'd0;
  localparam logic [1:0] CFG_HEADS_SECOND   = 2'd1;
  localparam logic [1:0] CFG_CONTROL_FIRST  = 2'd2;
  localparam logic [1:0] CFG_CONTROL_SECOND = 2'd3;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_DEVICE  = 2'd1,
    ST_INVALID     = 2'd2,
    ST_BEYOND_END  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_TRACK,
    S_RELOAD,
    S_DIV_HEAD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic        mode;
    logic [3:0]  device;
    logic [31:0] entry_start;
    logic [31:0] entry_length;
    logic        is_write;
    logic [31:0] byte_position;
    logic [15:0] byte_count;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  command_byte;
    logic [2:0]  byte_index;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       accept;
    logic       check;
    logic       div_step;
    logic       div_reload;
    logic [2:0] index;
  } ctrl_cmd_t;

  typedef struct packed {
    logic check_fail;
    logic failed;
  } ctrl_sts_t;

  // device to drive number, a compare table over the small device range
  function automatic logic [3:0] drive_of(logic [3:0] dev);
    logic [3:0] d;
    d = '0;
    for (int i = 1; i < 16; i++) begin
      if (int'(dev) >= i * DEVICES_PER_DRIVE) d = 4'(i);
    end
    return d;
  endfunction

endpackage

// ===== sv/disk_block_request_to_chs_command.sv =====
// Translates block requests into six-byte cylinder/head/sector controller
// commands. A load request (mode 0) writes one partition entry in the cycle
// it is taken and leaves busy low. A block request is checked, its absolute
// sector is divided by sectors per track and then by the drive's head count
// in a shared divider that retires eight quotient bits per cycle, and the
// six command bytes follow on consecutive cycles with strobe high. A block
// request holds busy high from acceptance until its last result, so no new
// request is taken before then; a rejected one gives its single result in
// the emit state that follows the check state. Results cannot be held off:
// the receiver must take each one in the cycle strobe is high. Configuration
// writes are always ready and should be made only while busy is low.
module disk_block_request_to_chs_command (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dbchs_pkg::req_t request,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  output logic            strobe,
  output dbchs_pkg::res_t result
);

  dbchs_pkg::ctrl_cmd_t cmd;
  dbchs_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  dbchs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (request.mode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  // tables, registers, divider and command bytes
  dbchs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .request   (request),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .result    (result)
  );

endmodule

// ===== sv/dbchs_ctrl.sv =====
module dbchs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 mode,
  input  dbchs_pkg::ctrl_sts_t sts,
  output dbchs_pkg::ctrl_cmd_t cmd,
  output logic                 busy,
  output logic                 strobe
);

  dbchs_pkg::state_t                state, state_next;
  logic [dbchs_pkg::STEP_W-1:0]     step, step_next;
  logic [2:0]                       index, index_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbchs_pkg::S_IDLE;
      step  <= '0;
      index <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      index <= index_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    step_next      = step;
    index_next     = index;
    cmd            = '0;
    cmd.index      = index;
    busy           = 1'b1;
    strobe         = 1'b0;
    unique case (state)
      dbchs_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
        step_next  = '0;
        index_next = '0;
        if (start && mode) state_next = dbchs_pkg::S_CHECK;
      end
      dbchs_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.check_fail) state_next = dbchs_pkg::S_EMIT;
        else                state_next = dbchs_pkg::S_DIV_TRACK;
      end
      dbchs_pkg::S_DIV_TRACK: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == dbchs_pkg::STEP_W'(dbchs_pkg::DIV_CYCLES - 1)) begin
          step_next  = '0;
          state_next = dbchs_pkg::S_RELOAD;
        end
      end
      dbchs_pkg::S_RELOAD: begin
        cmd.div_reload = 1'b1;
        state_next     = dbchs_pkg::S_DIV_HEAD;
      end
      dbchs_pkg::S_DIV_HEAD: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == dbchs_pkg::STEP_W'(dbchs_pkg::DIV_CYCLES - 1)) begin
          step_next  = '0;
          state_next = dbchs_pkg::S_EMIT;
        end
      end
      dbchs_pkg::S_EMIT: begin
        strobe     = 1'b1;
        index_next = index + 1'b1;
        if (sts.failed || index == dbchs_pkg::BYTE_CONTROL) begin
          index_next = '0;
          state_next = dbchs_pkg::S_IDLE;
        end
      end
      default: state_next = dbchs_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== sv/dbchs_datapath.sv =====
module dbchs_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  dbchs_pkg::ctrl_cmd_t cmd,
  input  dbchs_pkg::req_t      request,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output dbchs_pkg::ctrl_sts_t sts,
  output dbchs_pkg::res_t      result
);

  dbchs_pkg::req_t   req_q;
  dbchs_pkg::status_t status_q, check_status;

  logic [31:0] start_tab [dbchs_pkg::NUM_DEVICES];
  logic [31:0] len_tab   [dbchs_pkg::NUM_DEVICES];

  logic [4:0] heads_first, heads_second;
  logic [7:0] control_first, control_second;

  logic [dbchs_pkg::DIVIDEND_W-1:0] quo, quo_next, q;
  logic [dbchs_pkg::DIV_W-1:0]      rem, rem_next, r, divisor, track_q;
  logic [dbchs_pkg::DIV_W:0]        t;

  logic                               wr_ok, dev_ok, beyond;
  logic [dbchs_pkg::DEV_IDX_W-1:0]    rd_idx;
  logic [dbchs_pkg::BLK_SECTOR_W-1:0] blk_sector;
  logic [dbchs_pkg::SECTOR_W-1:0]     abs_sector, end_sector;
  logic [3:0]                         drive;
  logic [4:0]                         heads_sel, heads_eff;
  logic [7:0]                         control_sel;

  // request capture and partition table load
  assign wr_ok = int'(request.device) < dbchs_pkg::NUM_DEVICES;

  always_ff @(posedge clk) begin
    if (cmd.accept) req_q <= request;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dbchs_pkg::NUM_DEVICES; i++) begin
        start_tab[i] <= '0;
        len_tab[i]   <= '0;
      end
    end else if (cmd.accept && !request.mode && wr_ok) begin
      start_tab[request.device[dbchs_pkg::DEV_IDX_W-1:0]] <= request.entry_start;
      len_tab[request.device[dbchs_pkg::DEV_IDX_W-1:0]]   <= request.entry_length;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heads_first    <= 5'd4;
      heads_second   <= 5'd4;
      control_first  <= 8'd5;
      control_second <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dbchs_pkg::CFG_HEADS_FIRST:    heads_first    <= cfg_data[4:0];
        dbchs_pkg::CFG_HEADS_SECOND:   heads_second   <= cfg_data[4:0];
        dbchs_pkg::CFG_CONTROL_FIRST:  control_first  <= cfg_data;
        dbchs_pkg::CFG_CONTROL_SECOND: control_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // request checks and absolute sector
  assign dev_ok     = int'(req_q.device) < dbchs_pkg::NUM_DEVICES;
  assign rd_idx     = dev_ok ? req_q.device[dbchs_pkg::DEV_IDX_W-1:0] : '0;
  assign blk_sector = req_q.byte_position[31:dbchs_pkg::SECTOR_SHIFT];
  assign end_sector = dbchs_pkg::SECTOR_W'(blk_sector)
                    + dbchs_pkg::SECTOR_W'(dbchs_pkg::BLOCK_SECTORS);
  assign beyond     = end_sector > dbchs_pkg::SECTOR_W'(len_tab[rd_idx]);
  assign abs_sector = dbchs_pkg::SECTOR_W'(blk_sector)
                    + dbchs_pkg::SECTOR_W'(start_tab[rd_idx]);

  always_comb begin
    priority if (!dev_ok)
      check_status = dbchs_pkg::ST_BAD_DEVICE;
    else if (req_q.byte_count != 16'(dbchs_pkg::BLOCK_BYTES))
      check_status = dbchs_pkg::ST_INVALID;
    else if (req_q.byte_position[dbchs_pkg::BLOCK_SHIFT-1:0] != '0)
      check_status = dbchs_pkg::ST_INVALID;
    else if (beyond)
      check_status = dbchs_pkg::ST_BEYOND_END;
    else
      check_status = dbchs_pkg::ST_OK;
  end

  assign sts.check_fail = check_status != dbchs_pkg::ST_OK;
  assign sts.failed     = status_q != dbchs_pkg::ST_OK;

  // drive selection
  assign drive       = dbchs_pkg::drive_of(req_q.device);
  assign heads_sel   = (drive == 4'd0) ? heads_first : heads_second;
  assign heads_eff   = (heads_sel == 5'd0) ? 5'd1 : heads_sel;
  assign control_sel = (drive == 4'd0) ? control_first : control_second;

  // restoring divider, several quotient bits per cycle
  always_comb begin
    r = rem;
    q = quo;
    t = '0;
    for (int i = 0; i < dbchs_pkg::RADIX_BITS; i++) begin
      t = {r, q[dbchs_pkg::DIVIDEND_W-1]};
      q = {q[dbchs_pkg::DIVIDEND_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t    = t - {1'b0, divisor};
        q[0] = 1'b1;
      end
      r = t[dbchs_pkg::DIV_W-1:0];
    end
    rem_next = r;
    quo_next = q;
  end

  // first pass divides by sectors per track, second by heads
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      status_q <= check_status;
      quo      <= dbchs_pkg::DIVIDEND_W'(abs_sector);
      rem      <= '0;
      divisor  <= dbchs_pkg::DIV_W'(dbchs_pkg::SECTORS_PER_TRACK);
    end else if (cmd.div_reload) begin
      track_q <= rem;
      rem     <= '0;
      divisor <= dbchs_pkg::DIV_W'(heads_eff);
    end else if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  // command byte selection
  always_comb begin
    result.status       = status_q;
    result.byte_index   = cmd.index;
    result.last         = cmd.index == dbchs_pkg::BYTE_CONTROL;
    result.command_byte = '0;
    unique case (cmd.index)
      dbchs_pkg::BYTE_OPCODE:
        result.command_byte = req_q.is_write ? dbchs_pkg::OP_WRITE : dbchs_pkg::OP_READ;
      dbchs_pkg::BYTE_HEAD:
        result.command_byte = 8'(rem) | {drive[2:0], 5'b0};
      dbchs_pkg::BYTE_SECTOR:
        result.command_byte = {quo[9:8], 6'b0} | 8'(track_q);
      dbchs_pkg::BYTE_CYLINDER:
        result.command_byte = quo[7:0];
      dbchs_pkg::BYTE_BLOCKS:
        result.command_byte = 8'(dbchs_pkg::BLOCK_SECTORS);
      dbchs_pkg::BYTE_CONTROL:
        result.command_byte = control_sel;
      default:
        result.command_byte = '0;
    endcase
    // rejected request: a single zero byte
    if (status_q != dbchs_pkg::ST_OK) begin
      result.command_byte = '0;
      result.byte_index   = '0;
      result.last         = 1'b1;
    end
  end

endmodule
